@@ hdl/pnv_pkg.sv @@
package pnv_pkg;

    localparam int MAX_OUT = 256;
    localparam int MAX_IN  = 512;

    localparam int IN_W   = $clog2(MAX_IN + 1);
    localparam int OUT_W  = $clog2(MAX_OUT);
    localparam int COMP_W = 10;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int MAX_ITEMS  = 4;
    localparam int NEMIT      = 3;

    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] UTF_CLASS_2 = 2'd1;
    localparam logic [1:0] UTF_CLASS_3 = 2'd2;
    localparam logic [1:0] UTF_CLASS_4 = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       path_ok;
        logic       run_last;
    } item_t;

    function automatic logic bad_code(input logic [20:0] c);
        logic r;
        r = (c < 21'd32) || (c >= 21'h7f && c <= 21'h9f);
        r = r || c == 21'h3c || c == 21'h3e || c == 21'h3a || c == 21'h5c
              || c == 21'h7c || c == 21'h3f || c == 21'h2a || c == 21'h2f
              || c == 21'h22;
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

endpackage

@@ hdl/path_normalizer_validator.sv @@
// Streaming absolute-path normaliser and validator. One path byte is taken per
// cycle while in_stall is low (in_last marks the final byte); normalised bytes
// and a closing status word leave on the output channel, up to four words per
// input byte. Each input byte is fully processed in the cycle it is accepted,
// and its words go into an eight-word output queue; input is taken whenever
// the queue has room for four words, so the sustained byte rate is set by how
// fast the consumer drains the queue. After a failure only the status word follows.
module path_normalizer_validator
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_status,
    output logic       path_ok,
    output logic       run_last
);

    logic                            failed_reg, failed_next;
    logic                            started_reg, started_next;
    logic [pnv_pkg::IN_W-1:0]        in_count_reg, in_count_next;
    logic [pnv_pkg::OUT_W-1:0]       out_count_reg, out_count_next;
    logic [pnv_pkg::COMP_W-1:0]      comp_len_reg, comp_len_next;
    logic [2:0]                      stem_len_reg, stem_len_next;
    logic [31:0]                     stem_chars_reg, stem_chars_next;
    logic [7:0]                      prev_byte_reg, prev_byte_next;
    logic                            dot_pending_reg, dot_pending_next;
    logic [1:0]                      utf_rem_reg, utf_rem_next;
    logic [20:0]                     utf_val_reg, utf_val_next;
    logic [1:0]                      utf_cls_reg, utf_cls_next;

    pnv_pkg::item_t                  fifo_reg [pnv_pkg::FIFO_DEPTH];
    logic [pnv_pkg::FIFO_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [pnv_pkg::FIFO_AW:0]       count_reg;

    pnv_pkg::item_t                  items [pnv_pkg::MAX_ITEMS];
    logic [2:0]                      n_items;
    logic                            in_take, out_take;

    assign in_stall  = count_reg > (pnv_pkg::FIFO_AW+1)'(pnv_pkg::FIFO_DEPTH - pnv_pkg::MAX_ITEMS);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = count_reg != '0;
    assign out_take  = out_valid && !out_stall;
    assign out_byte  = fifo_reg[rd_ptr_reg].out_byte;
    assign is_status = fifo_reg[rd_ptr_reg].is_status;
    assign path_ok   = fifo_reg[rd_ptr_reg].path_ok;
    assign run_last  = fifo_reg[rd_ptr_reg].run_last;

    always_comb
    begin
        logic                        f;
        logic [pnv_pkg::OUT_W-1:0]   oc;
        logic [pnv_pkg::IN_W-1:0]    ic;
        logic                        a_v [pnv_pkg::NEMIT];
        logic [7:0]                  a_b [pnv_pkg::NEMIT];
        logic [20:0]                 uv;
        logic [20:0]                 umin;
        logic                        rsv;
        f    = failed_reg;
        oc   = out_count_reg;
        ic   = in_count_reg;
        uv   = '0;
        umin = '0;
        rsv  = 1'b0;
        for (int k = 0; k < pnv_pkg::NEMIT; k++)
        begin
            a_v[k] = 1'b0;
            a_b[k] = '0;
        end
        for (int k = 0; k < pnv_pkg::MAX_ITEMS; k++)
        begin
            items[k] = '0;
        end
        n_items          = '0;
        started_next     = started_reg;
        comp_len_next    = comp_len_reg;
        stem_len_next    = stem_len_reg;
        stem_chars_next  = stem_chars_reg;
        prev_byte_next   = prev_byte_reg;
        dot_pending_next = dot_pending_reg;
        utf_rem_next     = utf_rem_reg;
        utf_val_next     = utf_val_reg;
        utf_cls_next     = utf_cls_reg;

        if (ic < pnv_pkg::IN_W'(pnv_pkg::MAX_IN))
        begin
            ic = ic + 1'b1;
        end
        if (ic >= pnv_pkg::IN_W'(pnv_pkg::MAX_IN))
        begin
            f = 1'b1;
        end

        if (!started_reg)
        begin
            started_next = 1'b1;
            if (in_byte != pnv_pkg::CH_SLASH)
            begin
                f = 1'b1;
            end
            else
            begin
                a_v[0] = 1'b1;
                a_b[0] = pnv_pkg::CH_SLASH;
            end
        end
        else if (!f && in_byte == pnv_pkg::CH_SLASH)
        begin
            if (comp_len_reg != '0)
            begin
                if (!(comp_len_reg == pnv_pkg::COMP_W'(1) && dot_pending_reg))
                begin
                    if (stem_len_reg == 3'd3)
                    begin
                        rsv = stem_chars_reg[23:0] == 24'h6e6f63
                           || stem_chars_reg[23:0] == 24'h6e7270
                           || stem_chars_reg[23:0] == 24'h787561
                           || stem_chars_reg[23:0] == 24'h6c756e;
                    end
                    else if (stem_len_reg == 3'd4)
                    begin
                        rsv = (stem_chars_reg[23:0] == 24'h6d6f63
                            || stem_chars_reg[23:0] == 24'h74706c)
                           && stem_chars_reg[31:24] >= 8'h31
                           && stem_chars_reg[31:24] <= 8'h39;
                    end
                    if (utf_rem_reg != '0 || prev_byte_reg == pnv_pkg::CH_DOT
                        || prev_byte_reg == pnv_pkg::CH_SPACE || rsv)
                    begin
                        f = 1'b1;
                    end
                end
                comp_len_next    = '0;
                stem_len_next    = '0;
                stem_chars_next  = '0;
                prev_byte_next   = '0;
                dot_pending_next = 1'b0;
                utf_rem_next     = '0;
                utf_val_next     = '0;
                utf_cls_next     = '0;
            end
        end
        else if (!f)
        begin
            if (utf_rem_reg == '0)
            begin
                if (in_byte < 8'h80)
                begin
                    if (pnv_pkg::bad_code(21'(in_byte)))
                    begin
                        f = 1'b1;
                    end
                end
                else if (in_byte >= 8'hc2 && in_byte <= 8'hdf)
                begin
                    utf_rem_next = 2'd1;
                    utf_val_next = 21'(in_byte[4:0]);
                    utf_cls_next = pnv_pkg::UTF_CLASS_2;
                end
                else if (in_byte >= 8'he0 && in_byte <= 8'hef)
                begin
                    utf_rem_next = 2'd2;
                    utf_val_next = 21'(in_byte[3:0]);
                    utf_cls_next = pnv_pkg::UTF_CLASS_3;
                end
                else if (in_byte >= 8'hf0 && in_byte <= 8'hf4)
                begin
                    utf_rem_next = 2'd3;
                    utf_val_next = 21'(in_byte[2:0]);
                    utf_cls_next = pnv_pkg::UTF_CLASS_4;
                end
                else
                begin
                    f = 1'b1;
                end
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                f = 1'b1;
            end
            else
            begin
                uv           = {utf_val_reg[14:0], in_byte[5:0]};
                utf_val_next = uv;
                utf_rem_next = utf_rem_reg - 1'b1;
                if (utf_rem_reg == 2'd1)
                begin
                    umin = (utf_cls_reg == pnv_pkg::UTF_CLASS_2) ? 21'h80 :
                           (utf_cls_reg == pnv_pkg::UTF_CLASS_3) ? 21'h800 : 21'h10000;
                    if (uv < umin || uv > 21'h10ffff
                        || (uv >= 21'hd800 && uv <= 21'hdfff) || pnv_pkg::bad_code(uv))
                    begin
                        f = 1'b1;
                    end
                end
            end

            if (!f)
            begin
                if (stem_len_reg < 3'd5 && comp_len_reg <= pnv_pkg::COMP_W'(stem_len_reg)
                    && in_byte != pnv_pkg::CH_DOT)
                begin
                    if (stem_len_reg < 3'd4)
                    begin
                        stem_chars_next[8*stem_len_reg[1:0] +: 8] = pnv_pkg::to_lower(in_byte);
                    end
                    stem_len_next = stem_len_reg + 1'b1;
                end
                if (comp_len_reg != '1)
                begin
                    comp_len_next = comp_len_reg + 1'b1;
                end
                prev_byte_next = in_byte;
                if (comp_len_next == pnv_pkg::COMP_W'(1))
                begin
                    if (in_byte == pnv_pkg::CH_DOT)
                    begin
                        dot_pending_next = 1'b1;
                    end
                    else
                    begin
                        a_v[0] = oc > pnv_pkg::OUT_W'(1);
                        a_b[0] = pnv_pkg::CH_SLASH;
                        a_v[2] = 1'b1;
                        a_b[2] = in_byte;
                    end
                end
                else if (dot_pending_reg)
                begin
                    dot_pending_next = 1'b0;
                    a_v[0] = oc > pnv_pkg::OUT_W'(1);
                    a_b[0] = pnv_pkg::CH_SLASH;
                    a_v[1] = 1'b1;
                    a_b[1] = pnv_pkg::CH_DOT;
                    a_v[2] = 1'b1;
                    a_b[2] = in_byte;
                end
                else
                begin
                    a_v[2] = 1'b1;
                    a_b[2] = in_byte;
                end
            end
        end

        for (int k = 0; k < pnv_pkg::NEMIT; k++)
        begin
            if (a_v[k] && !f)
            begin
                if (oc >= pnv_pkg::OUT_W'(pnv_pkg::MAX_OUT - 1))
                begin
                    f = 1'b1;
                end
                else
                begin
                    items[n_items[1:0]].out_byte = a_b[k];
                    n_items = n_items + 1'b1;
                    oc = oc + 1'b1;
                end
            end
        end

        if (in_last)
        begin
            rsv = 1'b0;
            if (!f && comp_len_next != '0
                && !(comp_len_next == pnv_pkg::COMP_W'(1) && dot_pending_next))
            begin
                if (stem_len_next == 3'd3)
                begin
                    rsv = stem_chars_next[23:0] == 24'h6e6f63
                       || stem_chars_next[23:0] == 24'h6e7270
                       || stem_chars_next[23:0] == 24'h787561
                       || stem_chars_next[23:0] == 24'h6c756e;
                end
                else if (stem_len_next == 3'd4)
                begin
                    rsv = (stem_chars_next[23:0] == 24'h6d6f63
                        || stem_chars_next[23:0] == 24'h74706c)
                       && stem_chars_next[31:24] >= 8'h31
                       && stem_chars_next[31:24] <= 8'h39;
                end
                if (utf_rem_next != '0 || prev_byte_next == pnv_pkg::CH_DOT
                    || prev_byte_next == pnv_pkg::CH_SPACE || rsv)
                begin
                    f = 1'b1;
                end
            end
            items[n_items[1:0]].is_status = 1'b1;
            items[n_items[1:0]].path_ok   = !f;
            n_items = n_items + 1'b1;
            f                = 1'b0;
            started_next     = 1'b0;
            ic               = '0;
            oc               = '0;
            comp_len_next    = '0;
            stem_len_next    = '0;
            stem_chars_next  = '0;
            prev_byte_next   = '0;
            dot_pending_next = 1'b0;
            utf_rem_next     = '0;
            utf_val_next     = '0;
            utf_cls_next     = '0;
        end

        if (n_items != '0)
        begin
            items[2'(n_items - 1'b1)].run_last = 1'b1;
        end
        failed_next    = f;
        in_count_next  = ic;
        out_count_next = oc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg      <= 1'b0;
            started_reg     <= 1'b0;
            in_count_reg    <= '0;
            out_count_reg   <= '0;
            comp_len_reg    <= '0;
            stem_len_reg    <= '0;
            stem_chars_reg  <= '0;
            prev_byte_reg   <= '0;
            dot_pending_reg <= 1'b0;
            utf_rem_reg     <= '0;
            utf_val_reg     <= '0;
            utf_cls_reg     <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                failed_reg      <= failed_next;
                started_reg     <= started_next;
                in_count_reg    <= in_count_next;
                out_count_reg   <= out_count_next;
                comp_len_reg    <= comp_len_next;
                stem_len_reg    <= stem_len_next;
                stem_chars_reg  <= stem_chars_next;
                prev_byte_reg   <= prev_byte_next;
                dot_pending_reg <= dot_pending_next;
                utf_rem_reg     <= utf_rem_next;
                utf_val_reg     <= utf_val_next;
                utf_cls_reg     <= utf_cls_next;
                wr_ptr_reg      <= wr_ptr_reg + pnv_pkg::FIFO_AW'(n_items);
            end
            if (out_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (in_take ? (pnv_pkg::FIFO_AW+1)'(n_items) : '0)
                                   - (out_take ? (pnv_pkg::FIFO_AW+1)'(1) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int k = 0; k < pnv_pkg::MAX_ITEMS; k++)
            begin
                if (3'(k) < n_items)
                begin
                    fifo_reg[wr_ptr_reg + pnv_pkg::FIFO_AW'(k)] <= items[k];
                end
            end
        end
    end

endmodule

@@ hdl/pnv_checker.sv @@
module pnv_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_status,
    input logic       path_ok,
    input logic       run_last
);

    // a status word always closes the words of its input byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> run_last)
        else $error("status word without run_last");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> out_byte == 8'h00)
        else $error("status word carries a byte");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_ok |-> is_status)
        else $error("path_ok on a byte word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_status))
        else $error("stalled output word changed");

endmodule

bind path_normalizer_validator pnv_checker u_pnv_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_status (is_status),
    .path_ok   (path_ok),
    .run_last  (run_last)
);
